// ----- rtl/tmrbank_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timer bank package
// shared constants, slot store command types and sequencer states
// ----------------------------------------------------------------------------
package tmrbank_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int IDX_W       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int SLOT_W      = 4;
  localparam int TIME_W      = 32;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [TIME_W-1:0] time_t;

  // write command into the slot store
  typedef struct packed {
    logic  claim;
    logic  restart;
    logic  retire;
    idx_t  idx;
    time_t start;
    time_t interval;
    logic  periodic;
  } slot_wr_t;

  // one slot as read from the store
  typedef struct packed {
    logic  active;
    time_t start;
    time_t interval;
    logic  periodic;
  } slot_rd_t;

  // one result word
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              created;
    logic              fired;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CREATE = 4'b0010,
    S_TICK   = 4'b0100,
    S_CLOSE  = 4'b1000
  } seq_state_t;

endpackage
`default_nettype wire

// ----- rtl/tmrbank_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timer bank slot store
// active bits plus start, interval and mode of every slot
// ----------------------------------------------------------------------------
module tmrbank_store
  import tmrbank_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  slot_wr_t wr,
  input  idx_t     rd_idx,
  output slot_rd_t rd
);

  logic [TIMER_SLOTS-1:0] active_r;
  time_t                  start_r    [TIMER_SLOTS];
  time_t                  interval_r [TIMER_SLOTS];
  logic                   periodic_r [TIMER_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (wr.claim) begin
      active_r[wr.idx] <= 1'b1;
    end else if (wr.retire) begin
      active_r[wr.idx] <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (wr.claim) begin
      start_r[wr.idx]    <= wr.start;
      interval_r[wr.idx] <= wr.interval;
      periodic_r[wr.idx] <= wr.periodic;
    end else if (wr.restart) begin
      start_r[wr.idx]    <= wr.start;
    end
  end

  always_comb begin
    rd.active   = active_r[rd_idx];
    rd.start    = start_r[rd_idx];
    rd.interval = interval_r[rd_idx];
    rd.periodic = periodic_r[rd_idx];
  end

endmodule
`default_nettype wire

// ----- rtl/tmrbank_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timer bank expiry unit
// shared subtract and compare for the slot under scan
// ----------------------------------------------------------------------------
module tmrbank_unit
  import tmrbank_pkg::*;
(
  input  time_t    now,
  input  slot_rd_t slot,
  output logic     hit
);

  time_t elapsed;

  // wraps modulo 2^32
  assign elapsed = now - slot.start;
  assign hit     = slot.active && (elapsed >= slot.interval);

endmodule
`default_nettype wire

// ----- rtl/tmrbank_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timer bank sequencer
// walks the slots one per cycle while the output register is free, for create and tick words
// ----------------------------------------------------------------------------
module tmrbank_seq
  import tmrbank_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_kind,
  input  time_t    in_span_ms,
  input  logic     in_periodic,
  input  time_t    in_now_ms,
  input  logic     in_in_play,
  input  logic     out_free,
  input  slot_rd_t rd,
  input  logic     hit,
  output idx_t     rd_idx,
  output time_t    cur_now,
  output slot_wr_t wr,
  output logic     emit,
  output result_t  res
);

  seq_state_t state_r, state_nxt;
  idx_t       idx_r, idx_nxt;
  time_t      now_r;
  time_t      interval_r;
  logic       periodic_r;
  logic       idx_last;

  assign in_ready = (state_r == S_IDLE);
  assign rd_idx   = idx_r;
  assign cur_now  = now_r;
  assign idx_last = (idx_r == IDX_W'(TIMER_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r      <= in_now_ms;
      interval_r <= in_span_ms;
      periodic_r <= in_periodic;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    emit        = 1'b0;
    res         = '0;
    wr.claim    = 1'b0;
    wr.restart  = 1'b0;
    wr.retire   = 1'b0;
    wr.idx      = idx_r;
    wr.start    = now_r;
    wr.interval = interval_r;
    wr.periodic = periodic_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt = '0;
          if (in_kind == KIND_CREATE) begin
            state_nxt = S_CREATE;
          end else if (in_in_play) begin
            state_nxt = S_TICK;
          end else begin
            state_nxt = S_CLOSE;
          end
        end
      end
      S_CREATE: begin
        if (out_free) begin
          if (!rd.active) begin
            wr.claim    = 1'b1;
            emit        = 1'b1;
            res.slot    = SLOT_W'(idx_r);
            res.created = 1'b1;
            res.last    = 1'b1;
            state_nxt   = S_IDLE;
          end else if (idx_last) begin
            // pool full
            emit      = 1'b1;
            res.last  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + idx_t'(1);
          end
        end
      end
      S_TICK: begin
        if (out_free) begin
          if (hit) begin
            emit      = 1'b1;
            res.slot  = SLOT_W'(idx_r);
            res.fired = 1'b1;
            if (rd.periodic) begin
              wr.restart = 1'b1;
            end else begin
              wr.retire = 1'b1;
            end
          end
          if (idx_last) begin
            state_nxt = S_CLOSE;
          end else begin
            idx_nxt = idx_r + idx_t'(1);
          end
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          emit      = 1'b1;
          res.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/one_shot_periodic_timer_bank.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// one-shot / periodic timer bank
// first word: accept updates the state register, then the word is registered
// create: free-slot search, one slot per cycle while the output is free
// tick in play: one slot per cycle through the compare unit, then last word
// tick not in play: closing word only; output stalls hold the scan in place
// reset: all slots free at once, no clearing pass; slot payload is not reset
// ----------------------------------------------------------------------------
module one_shot_periodic_timer_bank
  import tmrbank_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [31:0]       in_span_ms,
  input  logic              in_periodic,
  input  logic [31:0]       in_now_ms,
  input  logic              in_in_play,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_created,
  output logic              out_fired,
  output logic              out_last
);

  // sequencer <-> store / compare unit
  slot_wr_t wr;
  slot_rd_t rd;
  idx_t     rd_idx;
  time_t    cur_now;
  logic     hit;
  logic     emit;
  result_t  res;

  // output register
  logic     out_valid_r;
  result_t  out_res_r;
  logic     out_free;

  // the scan only moves when the output register can take a word
  assign out_free = !out_valid_r || out_ready;

  tmrbank_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd     (rd)
  );

  // elapsed = now - start, compared against the interval
  tmrbank_unit u_unit (
    .now  (cur_now),
    .slot (rd),
    .hit  (hit)
  );

  tmrbank_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_span_ms     (in_span_ms),
    .in_periodic    (in_periodic),
    .in_now_ms      (in_now_ms),
    .in_in_play     (in_in_play),
    .out_free       (out_free),
    .rd             (rd),
    .hit            (hit),
    .rd_idx         (rd_idx),
    .cur_now        (cur_now),
    .wr             (wr),
    .emit           (emit),
    .res            (res)
  );

  // output word valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_slot    = out_res_r.slot;
  assign out_created = out_res_r.created;
  assign out_fired   = out_res_r.fired;
  assign out_last    = out_res_r.last;

endmodule
`default_nettype wire
